// ===== rtl/etfp_pkg.sv =====
// ----------------------------------------------------------------------------
// etfp_pkg: shared types and constants
// Widths, frame layout, the CRC-8 step and the word passed from the front
// end to the back end of the telemetry frame parser.
// ----------------------------------------------------------------------------
package etfp_pkg;

    localparam int BYTE_W        = 8;
    localparam int PAYLOAD_BYTES = 9;
    localparam int IDX_W         = 4;      // holds 0..PAYLOAD_BYTES
    localparam int WORD_W        = 16;
    localparam int NUM_WORDS     = 4;
    localparam int RPM_W         = 23;
    localparam int SCALE_W       = 7;
    localparam int FIFO_DEPTH    = 2;

    localparam logic [BYTE_W-1:0]  CRC_POLY  = 8'h07;
    localparam logic [SCALE_W-1:0] RPM_SCALE = 7'd100;

    // Word index of each telemetry field in the payload
    localparam int W_VOLT = 0;
    localparam int W_CURR = 1;
    localparam int W_CAP  = 2;
    localparam int W_ERPM = 3;

    typedef logic [PAYLOAD_BYTES-1:0][BYTE_W-1:0] t_payload;

    typedef struct packed {
        logic                good;
        logic [BYTE_W-1:0]   check;
        t_payload            payload;
    } t_frame;

    typedef struct packed {
        logic   push;
        t_frame frame;
    } t_push;

    // One byte of CRC-8, MSB first, no reflection
    function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] acc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = acc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Big-endian word w of the payload (bytes 1+2w and 2+2w)
    function automatic logic [WORD_W-1:0] payload_word(input t_payload p, input int w);
        return {p[1 + 2 * w], p[2 + 2 * w]};
    endfunction

endpackage

// ===== rtl/etfp_if.sv =====
// ----------------------------------------------------------------------------
// etfp interfaces: byte, result and configuration channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface etfp_in_if;
    import etfp_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_start;
    modport source (output valid, rx_byte, frame_start, input ready);
    modport sink   (input valid, rx_byte, frame_start, output ready);
endinterface

interface etfp_out_if;
    import etfp_pkg::*;
    logic              valid;
    logic              ready;
    logic              status;
    logic [BYTE_W-1:0] temperature;
    logic [WORD_W-1:0] voltage_centivolts;
    logic [WORD_W-1:0] current_centiamps;
    logic [WORD_W-1:0] capacity;
    logic [WORD_W-1:0] electrical_rpm;
    logic [RPM_W-1:0]  mechanical_rpm;
    logic [BYTE_W-1:0] check_byte;
    modport source (output valid, status, temperature, voltage_centivolts,
                    current_centiamps, capacity, electrical_rpm, mechanical_rpm,
                    check_byte, input ready);
    modport sink   (input valid, status, temperature, voltage_centivolts,
                    current_centiamps, capacity, electrical_rpm, mechanical_rpm,
                    check_byte, output ready);
endinterface

interface etfp_cfg_if;
    import etfp_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pp_count;
    modport source (output valid, pp_count, input ready);
    modport sink   (input valid, pp_count, output ready);
endinterface

// ===== rtl/etfp_front.sv =====
// ----------------------------------------------------------------------------
// etfp_front: byte collector
// Counts frame bytes, runs the CRC, holds the payload and hands each
// completed frame (with its CRC verdict) to the frame queue.
// ----------------------------------------------------------------------------
module etfp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [etfp_pkg::BYTE_W-1:0]   i_rx_byte,
    input  logic                          i_frame_start,
    input  logic                          i_full,
    output logic                          o_ready,
    output etfp_pkg::t_push               o_push
);
    import etfp_pkg::*;

    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [BYTE_W-1:0] r_crc, n_crc;
    t_payload          r_store;
    logic              accept;
    logic [IDX_W-1:0]  cur_idx;
    logic [BYTE_W-1:0] cur_crc;
    logic              is_check;

    // Stall whole channel while the queue is full; keeps ready data-independent
    assign o_ready  = !i_full;
    assign accept   = i_valid && o_ready;
    assign cur_idx  = i_frame_start ? '0 : r_idx;
    assign cur_crc  = i_frame_start ? '0 : r_crc;
    assign is_check = (cur_idx == IDX_W'(PAYLOAD_BYTES));

    always_comb begin
        n_idx = r_idx;
        n_crc = r_crc;
        if (accept) begin
            if (is_check) begin
                n_idx = '0;
                n_crc = '0;
            end else begin
                n_idx = cur_idx + IDX_W'(1);
                n_crc = crc8_step(cur_crc, i_rx_byte);
            end
        end
    end

    always_comb begin
        o_push.push          = accept && is_check;
        o_push.frame.good    = (cur_crc == i_rx_byte);
        o_push.frame.check   = i_rx_byte;
        o_push.frame.payload = r_store;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_crc <= '0;
        end else begin
            r_idx <= n_idx;
            r_crc <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !is_check) begin
            r_store[cur_idx] <= i_rx_byte;
        end
    end

endmodule

// ===== rtl/etfp_fifo.sv =====
// ----------------------------------------------------------------------------
// etfp_fifo: frame queue
// Small register FIFO of completed frames between front and back end.
// ----------------------------------------------------------------------------
module etfp_fifo #(
    parameter int DEPTH = etfp_pkg::FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  etfp_pkg::t_push  i_push,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output etfp_pkg::t_frame o_frame
);
    import etfp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_frame           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_frame = r_mem[r_rd_ptr];
    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (do_pop)  r_rd_ptr <= ptr_inc(r_rd_ptr);
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.frame;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push |-> !o_full)
        else $error("frame pushed into full queue");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue fill count lost a push");
`endif

endmodule

// ===== rtl/etfp_back.sv =====
// ----------------------------------------------------------------------------
// etfp_back: frame executor
// Updates last-good telemetry, computes mechanical rpm with a radix-2
// restoring divider and drives the registered result channel.
// ----------------------------------------------------------------------------
module etfp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  etfp_pkg::t_frame              i_frame,
    input  logic [etfp_pkg::BYTE_W-1:0]   i_pp_count,
    output logic                          o_pop,
    etfp_out_if.source                    o_out
);
    import etfp_pkg::*;

    localparam int CNT_W = $clog2(RPM_W);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state             r_state;
    logic               r_status;
    logic [BYTE_W-1:0]  r_lg_temp;
    logic [WORD_W-1:0]  r_lg_words [NUM_WORDS];
    logic [RPM_W-1:0]   r_lg_rpm;
    logic [BYTE_W-1:0]  r_lg_check;

    logic [RPM_W-1:0]   r_quo, n_quo;
    logic [BYTE_W-1:0]  r_rem, n_rem;
    logic [BYTE_W-1:0]  r_div;
    logic [CNT_W-1:0]   r_cnt;
    logic [BYTE_W:0]    rem_shift;
    logic               ge;

    logic               r_out_valid;
    logic               out_free;
    logic               load_out;
    logic [WORD_W-1:0]  erpm_in;

    assign o_pop    = (r_state == S_IDLE) && i_valid;
    assign out_free = !r_out_valid || o_out.ready;
    assign load_out = (r_state == S_OUT) && out_free;
    assign erpm_in  = payload_word(i_frame.payload, W_ERPM);

    // one quotient bit per cycle
    always_comb begin
        rem_shift = {r_rem, r_quo[RPM_W-1]};
        ge        = (rem_shift >= {1'b0, r_div});
        n_rem     = ge ? BYTE_W'(rem_shift - {1'b0, r_div}) : rem_shift[BYTE_W-1:0];
        n_quo     = {r_quo[RPM_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= 1'b0;
            r_lg_temp   <= '0;
            r_lg_rpm    <= '0;
            r_lg_check  <= '0;
            r_out_valid <= 1'b0;
            for (int w = 0; w < NUM_WORDS; w++) r_lg_words[w] <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_status <= !i_frame.good;
                        if (i_frame.good) begin
                            r_lg_temp  <= i_frame.payload[0];
                            r_lg_check <= i_frame.check;
                            for (int w = 0; w < NUM_WORDS; w++) begin
                                r_lg_words[w] <= payload_word(i_frame.payload, w);
                            end
                            if (i_pp_count == '0) begin
                                r_lg_rpm <= '0;
                                r_state  <= S_OUT;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_DIV: begin
                    if (r_cnt == CNT_W'(RPM_W - 1)) begin
                        r_lg_rpm <= n_quo;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase

            if (load_out)          r_out_valid <= 1'b1;
            else if (o_out.ready)  r_out_valid <= 1'b0;
        end
    end

    // divider datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_quo <= RPM_W'(erpm_in) * RPM_W'(RPM_SCALE);
            r_rem <= '0;
            r_div <= i_pp_count;
            r_cnt <= '0;
        end else if (r_state == S_DIV) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_out.status             <= r_status;
            o_out.temperature        <= r_lg_temp;
            o_out.voltage_centivolts <= r_lg_words[W_VOLT];
            o_out.current_centiamps  <= r_lg_words[W_CURR];
            o_out.capacity           <= r_lg_words[W_CAP];
            o_out.electrical_rpm     <= r_lg_words[W_ERPM];
            o_out.mechanical_rpm     <= r_lg_rpm;
            o_out.check_byte         <= r_lg_check;
        end
    end

    assign o_out.valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div != '0))
        else $error("divider running with zero pole pairs");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");
    a_bad_keeps_rpm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !i_frame.good) |=> $stable(r_lg_rpm))
        else $error("bad frame changed last good rpm");
`endif

endmodule

// ===== rtl/esc_telemetry_frame_parser_unit.sv =====
// ----------------------------------------------------------------------------
// esc_telemetry_frame_parser_unit: motor controller telemetry frame parser
// Collects ten-byte telemetry frames, checks the CRC-8 and reports decoded
// fields plus mechanical rpm for every completed frame.
// ----------------------------------------------------------------------------
// Usage:
//  - i_in carries one received byte per word plus frame_start, which drops
//    any partial frame and makes the byte payload byte 0.
//  - Nine payload bytes then a CRC byte (poly 0x07, init 0, MSB first).
//    Every tenth byte yields one word on o_out: status 0 with fresh fields on
//    a good CRC, status 1 with the last good fields on a mismatch.
//  - i_cfg writes the pole-pair count; always ready. Write it only while idle.
//  - A check byte is queued when it is accepted and popped once the back
//    end is idle, loading the divider with erpm*100; bit-serial division
//    of the 23-bit quotient (one quotient bit per cycle) then loads the
//    result register and raises o_out.valid once the output is free.
//    Bad frames and zero pole pairs skip the divider.
//  - A two-frame queue sits between collector and divider, so bytes keep
//    flowing while a result waits on o_out; i_in.ready only drops when the
//    queue is full.
//  - Reset (synchronous, active low) clears the byte count, CRC, last good
//    fields, the pole-pair count and all handshake state.
// ----------------------------------------------------------------------------
module esc_telemetry_frame_parser_unit #(
    parameter int FIFO_DEPTH = etfp_pkg::FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    etfp_in_if.sink     i_in,
    etfp_cfg_if.sink    i_cfg,
    etfp_out_if.source  o_out
);
    import etfp_pkg::*;

    logic              r_pp_set;
    logic [BYTE_W-1:0] r_pp;
    t_push             push;
    t_frame            q_frame;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;

    // config register, single entry
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp     <= '0;
            r_pp_set <= 1'b0;
        end else if (i_cfg.valid) begin
            r_pp     <= i_cfg.pp_count;
            r_pp_set <= 1'b1;   // marks that pole pairs were programmed
        end
    end

    // front end: byte count, CRC, payload capture
    etfp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in.valid),
        .i_rx_byte     (i_in.rx_byte),
        .i_frame_start (i_in.frame_start),
        .i_full        (q_full),
        .o_ready       (i_in.ready),
        .o_push        (push)
    );

    // decouples byte intake from the divider
    etfp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_frame (q_frame)
    );

    // back end: field update, rpm division, result register
    etfp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_frame      (q_frame),
        .i_pp_count   (r_pp),
        .o_pop        (q_pop),
        .o_out        (o_out)
    );

`ifndef NO_ASSERTIONS
    a_cfg_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pp != '0) |-> r_pp_set)
        else $error("nonzero pole pairs without a config write");
    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.push |-> (i_in.valid && i_in.ready))
        else $error("frame pushed without an accepted byte");
    a_stall_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !i_in.ready)
        else $error("byte accepted while frame queue full");
`endif

endmodule
